FILE: rtl/pcxrle_pkg.sv
// Shared types and constants for the PCX run-length palette decoder.
`default_nettype none
package pcxrle_pkg;

    localparam int DIM_W       = 17;
    localparam int COORD_W     = 16;
    localparam int RGB_W       = 24;
    localparam int BYTE_W      = 8;
    localparam int RUN_W       = 6;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0]       RUN_MARK = 2'b11;
    localparam logic [RUN_W-1:0] RUN_MASK = 6'h3f;
    localparam logic [DIM_W-1:0] DIM_MAX  = 17'd65536;
    localparam logic [DIM_W-1:0] WIDTH_RESET  = 17'd320;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 17'd200;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        KIND_PAL,
        KIND_MARK,
        KIND_PLAIN
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] idx;
        logic [RGB_W-1:0]  color;
    } t_cmd;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } t_dims;

endpackage
`default_nettype wire

FILE: rtl/pcxrle_front.sv
// Input stage: accepts words and classifies them into decoder commands.
`default_nettype none
module pcxrle_front (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_valid,
    output logic                             o_ready,
    input  wire                              i_action,
    input  wire  [pcxrle_pkg::BYTE_W-1:0]    i_palette_index,
    input  wire  [pcxrle_pkg::RGB_W-1:0]     i_palette_color,
    input  wire  [pcxrle_pkg::BYTE_W-1:0]    i_coded_byte,
    output logic                             o_cmd_valid,
    input  wire                              i_cmd_ready,
    output pcxrle_pkg::t_cmd                 o_cmd
);

    logic             r_valid;
    pcxrle_pkg::t_cmd r_cmd;
    pcxrle_pkg::t_cmd n_cmd;

    always_comb begin
        n_cmd.color = i_palette_color;
        if (!i_action) begin
            n_cmd.kind = pcxrle_pkg::KIND_PAL;
            n_cmd.idx  = i_palette_index;
        end else begin
            n_cmd.idx = i_coded_byte;
            if (i_coded_byte[pcxrle_pkg::BYTE_W-1 -: 2] == pcxrle_pkg::RUN_MARK) begin
                n_cmd.kind = pcxrle_pkg::KIND_MARK;
            end else begin
                n_cmd.kind = pcxrle_pkg::KIND_PLAIN;
            end
        end
    end

    assign o_ready     = !r_valid || i_cmd_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_cmd <= n_cmd;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/pcxrle_queue.sv
// Short command queue between the front and back stages.
`default_nettype none
module pcxrle_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push_valid,
    output logic                o_push_ready,
    input  pcxrle_pkg::t_cmd    i_push_cmd,
    output logic                o_pop_valid,
    input  wire                 i_pop_ready,
    output pcxrle_pkg::t_cmd    o_pop_cmd
);

    pcxrle_pkg::t_cmd                  r_slot [pcxrle_pkg::QUEUE_DEPTH];
    logic [pcxrle_pkg::QPTR_W-1:0]     r_wr_ptr;
    logic [pcxrle_pkg::QPTR_W-1:0]     r_rd_ptr;
    logic [pcxrle_pkg::QCNT_W-1:0]     r_count;
    logic                              push;
    logic                              pop;

    assign o_push_ready = r_count != pcxrle_pkg::QCNT_W'(pcxrle_pkg::QUEUE_DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_pop_cmd    = r_slot[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/pcxrle_back.sv
// Execution stage: palette table, run expansion, pixel position and output word.
`default_nettype none
module pcxrle_back (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  pcxrle_pkg::t_dims                 i_dims,
    input  wire                               i_cmd_valid,
    output logic                              o_cmd_ready,
    input  pcxrle_pkg::t_cmd                  i_cmd,
    output logic                              o_valid,
    input  wire                               i_ready,
    output logic [pcxrle_pkg::RGB_W-1:0]      o_pixel_rgb,
    output logic [pcxrle_pkg::COORD_W-1:0]    o_column,
    output logic [pcxrle_pkg::COORD_W-1:0]    o_row,
    output logic                              o_line_end,
    output logic                              o_image_end,
    output logic                              o_run_last
);

    logic [pcxrle_pkg::RGB_W-1:0]   r_palette [256];
    logic [pcxrle_pkg::RGB_W-1:0]   r_rgb;

    logic                           r_run_pending;
    logic [pcxrle_pkg::RUN_W-1:0]   r_pending_count;
    logic                           r_run_active;
    logic [pcxrle_pkg::RUN_W-1:0]   r_run_left;
    logic [pcxrle_pkg::BYTE_W-1:0]  r_run_idx;
    logic [pcxrle_pkg::DIM_W-1:0]   r_col;
    logic [pcxrle_pkg::DIM_W-1:0]   r_row;

    logic                           r_out_valid;
    logic [pcxrle_pkg::COORD_W-1:0] r_out_col;
    logic [pcxrle_pkg::COORD_W-1:0] r_out_row;
    logic                           r_out_le;
    logic                           r_out_ie;
    logic                           r_out_last;

    logic                           out_free;
    logic                           complete;
    logic                           is_data;
    logic                           takes_pixels;
    logic [pcxrle_pkg::RUN_W-1:0]   head_count;
    logic                           head_emit;
    logic                           emit;
    logic                           pop;
    logic [pcxrle_pkg::BYTE_W-1:0]  pix_idx;
    logic [pcxrle_pkg::RUN_W-1:0]   pix_left;
    logic                           pix_le;
    logic                           pix_ie;
    logic                           pix_last;

    assign out_free = !r_out_valid || i_ready;
    assign complete = r_row >= i_dims.height;
    assign is_data  = i_cmd.kind != pcxrle_pkg::KIND_PAL;

    // The byte after a run header is always an index, whatever its top bits.
    assign takes_pixels = r_run_pending || (i_cmd.kind == pcxrle_pkg::KIND_PLAIN);
    assign head_count   = r_run_pending ? r_pending_count : pcxrle_pkg::RUN_W'(1);
    assign head_emit    = is_data && !complete && takes_pixels && (head_count != '0)
                          && (r_col < i_dims.width);

    assign pop  = !r_run_active && i_cmd_valid && (!head_emit || out_free);
    assign emit = out_free && (r_run_active || (i_cmd_valid && head_emit));
    assign o_cmd_ready = pop;

    assign pix_idx  = r_run_active ? r_run_idx : i_cmd.idx;
    assign pix_left = r_run_active ? r_run_left : head_count;
    assign pix_le   = (r_col + 1'b1) == i_dims.width;
    assign pix_ie   = pix_le && ((r_row + 1'b1) == i_dims.height);
    assign pix_last = pix_le || (pix_left == pcxrle_pkg::RUN_W'(1));

    always_ff @(posedge i_clk) begin
        if (pop && !is_data) begin
            r_palette[i_cmd.idx] <= i_cmd.color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_rgb <= r_palette[pix_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_pending   <= 1'b0;
            r_pending_count <= '0;
            r_run_active    <= 1'b0;
            r_col           <= '0;
            r_row           <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (pop && is_data && !complete) begin
                if (r_run_pending) begin
                    r_run_pending   <= 1'b0;
                    r_pending_count <= '0;
                end else if (i_cmd.kind == pcxrle_pkg::KIND_MARK) begin
                    r_run_pending   <= 1'b1;
                    r_pending_count <= i_cmd.idx[pcxrle_pkg::RUN_W-1:0]
                                       & pcxrle_pkg::RUN_MASK;
                end
                // A stale column closes the line and the item's pixels are lost.
                if (takes_pixels && (head_count != '0) && (r_col >= i_dims.width)) begin
                    r_col <= '0;
                    r_row <= r_row + 1'b1;
                end
            end
            if (emit) begin
                r_run_active <= !pix_last;
                if (pix_le) begin
                    r_col <= '0;
                    r_row <= r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_run_idx  <= pix_idx;
            r_run_left <= pix_left - 1'b1;
            r_out_col  <= r_col[pcxrle_pkg::COORD_W-1:0];
            r_out_row  <= r_row[pcxrle_pkg::COORD_W-1:0];
            r_out_le   <= pix_le;
            r_out_ie   <= pix_ie;
            r_out_last <= pix_last;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_pixel_rgb = r_rgb;
    assign o_column    = r_out_col;
    assign o_row       = r_out_row;
    assign o_line_end  = r_out_le;
    assign o_image_end = r_out_ie;
    assign o_run_last  = r_out_last;

endmodule
`default_nettype wire

FILE: rtl/pcx_rle_palette_decoder_core.sv
// Top level of the PCX run-length palette decoder: size registers and stage wiring.
//
//   channel   direction  handshake            payload
//   input     in         i_valid / o_ready    i_action, i_palette_index,
//                                             i_palette_color, i_coded_byte
//   output    out        o_valid / i_ready    o_pixel_rgb, o_column, o_row,
//                                             o_line_end, o_image_end, o_run_last
//   config    in         i_cfg_we             i_cfg_index, i_cfg_data
//
// Palette writes, run headers and literal bytes are taken one per cycle while no
// run is expanding and, for literal bytes, the output is not stalled. A run holds
// the back stage while it expands, one pixel per cycle unless the output stalls,
// and the four-word queue fills behind it before the input stalls. A pixel's word
// passes through the input register and the queue, and the registered palette
// read lands with the output word. Reset clears the run and position state; the
// palette holds no defined values until written, so there is no clearing pass.
`default_nettype none
module pcx_rle_palette_decoder_core (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire                              i_cfg_index,
    input  wire  [pcxrle_pkg::DIM_W-1:0]     i_cfg_data,
    input  wire                              i_valid,
    output logic                             o_ready,
    input  wire                              i_action,
    input  wire  [pcxrle_pkg::BYTE_W-1:0]    i_palette_index,
    input  wire  [pcxrle_pkg::RGB_W-1:0]     i_palette_color,
    input  wire  [pcxrle_pkg::BYTE_W-1:0]    i_coded_byte,
    output logic                             o_valid,
    input  wire                              i_ready,
    output logic [pcxrle_pkg::RGB_W-1:0]     o_pixel_rgb,
    output logic [pcxrle_pkg::COORD_W-1:0]   o_column,
    output logic [pcxrle_pkg::COORD_W-1:0]   o_row,
    output logic                             o_line_end,
    output logic                             o_image_end,
    output logic                             o_run_last
);

    pcxrle_pkg::t_dims              r_dims;
    logic [pcxrle_pkg::DIM_W-1:0]   cfg_clamped;

    logic                           f_valid;
    logic                           f_ready;
    pcxrle_pkg::t_cmd               f_cmd;
    logic                           q_valid;
    logic                           q_ready;
    pcxrle_pkg::t_cmd               q_cmd;

    // Sizes above the largest line or image length are stored as that length.
    assign cfg_clamped = (i_cfg_data > pcxrle_pkg::DIM_MAX) ? pcxrle_pkg::DIM_MAX : i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims.width  <= pcxrle_pkg::WIDTH_RESET;
            r_dims.height <= pcxrle_pkg::HEIGHT_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == pcxrle_pkg::REG_WIDTH) begin
                r_dims.width <= cfg_clamped;
            end else begin
                r_dims.height <= cfg_clamped;
            end
        end
    end

    pcxrle_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_action        (i_action),
        .i_palette_index (i_palette_index),
        .i_palette_color (i_palette_color),
        .i_coded_byte    (i_coded_byte),
        .o_cmd_valid     (f_valid),
        .i_cmd_ready     (f_ready),
        .o_cmd           (f_cmd)
    );

    pcxrle_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_cmd   (f_cmd),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_cmd    (q_cmd)
    );

    pcxrle_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dims      (r_dims),
        .i_cmd_valid (q_valid),
        .o_cmd_ready (q_ready),
        .i_cmd       (q_cmd),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_pixel_rgb (o_pixel_rgb),
        .o_column    (o_column),
        .o_row       (o_row),
        .o_line_end  (o_line_end),
        .o_image_end (o_image_end),
        .o_run_last  (o_run_last)
    );

endmodule
`default_nettype wire
